// ----- src/obm_pkg.sv -----
// Package for the byte-level 1-Wire bus master.
// Payload types, command and register codes, widths and register reset values.
// Used by the channel interfaces and by onewire_bus_master_byte_top.
package obm_pkg;

	localparam int REG_W           = 10;
	localparam int REG_COUNT       = 8;
	localparam int REG_IDX_W       = 3;
	localparam int CFG_IDX_W       = 4;
	localparam int TIMER_BITS_DEF  = 10;
	localparam int BITS_PER_BYTE   = 8;
	localparam int BIT_CNT_W       = 3;
	localparam int PHASE_W         = 4;

	// command codes carried in func
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_RESET = 2'd1;
	localparam logic [1:0] FUNC_WRITE = 2'd2;
	localparam logic [1:0] FUNC_READ  = 2'd3;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] IDX_RESET_LOW     = 3'd0;
	localparam logic [REG_IDX_W-1:0] IDX_PRESENCE_WAIT = 3'd1;
	localparam logic [REG_IDX_W-1:0] IDX_RESET_TAIL    = 3'd2;
	localparam logic [REG_IDX_W-1:0] IDX_WRITE_ONE_LOW = 3'd3;
	localparam logic [REG_IDX_W-1:0] IDX_WRITE_ZERO_LOW = 3'd4;
	localparam logic [REG_IDX_W-1:0] IDX_SLOT_TAIL     = 3'd5;
	localparam logic [REG_IDX_W-1:0] IDX_READ_LOW      = 3'd6;
	localparam logic [REG_IDX_W-1:0] IDX_RECOVERY      = 3'd7;

	// register reset values, in index order
	localparam logic [REG_W-1:0] RST_RESET_LOW      = 10'd480;
	localparam logic [REG_W-1:0] RST_PRESENCE_WAIT  = 10'd60;
	localparam logic [REG_W-1:0] RST_RESET_TAIL     = 10'd480;
	localparam logic [REG_W-1:0] RST_WRITE_ONE_LOW  = 10'd1;
	localparam logic [REG_W-1:0] RST_WRITE_ZERO_LOW = 10'd60;
	localparam logic [REG_W-1:0] RST_SLOT_TAIL      = 10'd60;
	localparam logic [REG_W-1:0] RST_READ_LOW       = 10'd2;
	localparam logic [REG_W-1:0] RST_RECOVERY       = 10'd1;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] data_byte;
		logic       line_level;
	} item_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       no_presence;
		logic       rejected;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [REG_W-1:0]     data;
	} cfg_t;

endpackage

// ----- src/obm_ifs.sv -----
// Valid/ready channel interfaces for the 1-Wire bus master.
// Depends on obm_pkg for the payload types.

interface obm_item_if;
	import obm_pkg::*;
	logic  valid;
	logic  ready;
	item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface obm_result_if;
	import obm_pkg::*;
	logic    valid;
	logic    ready;
	result_t payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface obm_cfg_if;
	import obm_pkg::*;
	logic valid;
	logic ready;
	cfg_t payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/onewire_bus_master_byte_top.sv -----
// Byte-level 1-Wire bus master, one input transfer per microsecond tick.
// Depends on obm_pkg and the channel interfaces in obm_ifs.sv.
//
//  channel  dir  payload                                           transfer when
//  item     in   func, data_byte, line_level                       valid & ready
//  result   out  drive_low, busy_res, done_res, read_data,
//                no_presence, rejected                             valid & ready
//  cfg      in   index (4b), data (10b)                            valid & ready
//
// Every item gives exactly one result, registered and offered in the cycle after the item transfer.
// Throughput is one item per clock: the phase sequencer state and the result register
// update in the same edge; item.ready drops only while a result waits and result.ready is low.
// cfg.ready is always high; writes to indexes above seven are dropped.
// arst_n clears the sequencer, the presence flag (to "no device") and the result valid;
// configuration registers return to their default timings.
module onewire_bus_master_byte_top #(
	parameter int TIMER_BITS = obm_pkg::TIMER_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	obm_item_if.sink    item,
	obm_result_if.source result,
	obm_cfg_if.sink     cfg
);
	import obm_pkg::*;

	localparam int TW = TIMER_BITS;
	localparam int CW = (TW > REG_W) ? TW : REG_W;
	localparam logic [TW-1:0] TMAX = '1;

	// sequencer phase codes
	localparam logic [PHASE_W-1:0] PH_IDLE     = 4'd0;
	localparam logic [PHASE_W-1:0] PH_RST_LOW  = 4'd1;
	localparam logic [PHASE_W-1:0] PH_RST_WAIT = 4'd2;
	localparam logic [PHASE_W-1:0] PH_RST_TAIL = 4'd3;
	localparam logic [PHASE_W-1:0] PH_W_LOW    = 4'd4;
	localparam logic [PHASE_W-1:0] PH_W_TAIL   = 4'd5;
	localparam logic [PHASE_W-1:0] PH_R_LOW    = 4'd6;
	localparam logic [PHASE_W-1:0] PH_R_SAMPLE = 4'd7;
	localparam logic [PHASE_W-1:0] PH_R_TAIL   = 4'd8;

	typedef struct packed {
		logic [PHASE_W-1:0]   phase;
		logic [TW-1:0]        timer;
		logic [BIT_CNT_W-1:0] bit_count;
		logic [7:0]           send_shift;
	} seq_t;

	logic [REG_W-1:0] cfg_q [REG_COUNT];

	logic [PHASE_W-1:0]   phase_q;
	logic [TW-1:0]        timer_q;
	logic [BIT_CNT_W-1:0] bit_count_q;
	logic [7:0]           send_shift_q;
	logic [7:0]           receive_shift_q;
	logic                 presence_q;

	logic    res_valid_q;
	result_t res_q;

	logic    item_xfer;
	seq_t    s_start, s_adv1, s_adv2, s_next;
	logic [7:0] recv_next;
	logic    pres_next;
	result_t res_next;

	// clamp a register value into the timer, optionally forcing a minimum of one
	function automatic logic [TW-1:0] fit(input logic [REG_W-1:0] v, input logic at_least_one);
		logic [CW-1:0] ve;
		ve = CW'(v);
		if (at_least_one && v == '0) begin
			ve = CW'(1);
		end
		if (ve > CW'(TMAX)) begin
			ve = CW'(TMAX);
		end
		return TW'(ve);
	endfunction

	// enter a phase: load its length
	function automatic seq_t go(input seq_t s, input logic [PHASE_W-1:0] p);
		seq_t r;
		r = s;
		r.phase = p;
		unique case (p)
			PH_RST_LOW:  r.timer = fit(cfg_q[IDX_RESET_LOW], 1'b1);
			PH_RST_WAIT: r.timer = fit(cfg_q[IDX_PRESENCE_WAIT], 1'b1);
			PH_RST_TAIL: r.timer = fit(cfg_q[IDX_RESET_TAIL], 1'b0);
			PH_W_LOW:    r.timer = s.send_shift[0] ? fit(cfg_q[IDX_WRITE_ONE_LOW], 1'b1)
			                                       : fit(cfg_q[IDX_WRITE_ZERO_LOW], 1'b1);
			PH_W_TAIL:   r.timer = s.send_shift[0] ? fit(cfg_q[IDX_SLOT_TAIL], 1'b0)
			                                       : fit(cfg_q[IDX_RECOVERY], 1'b0);
			PH_R_LOW:    r.timer = fit(cfg_q[IDX_READ_LOW], 1'b1);
			PH_R_SAMPLE: r.timer = TW'(1);
			PH_R_TAIL:   r.timer = fit(cfg_q[IDX_SLOT_TAIL], 1'b0);
			default: begin
				r.phase = PH_IDLE;
				r.timer = '0;
			end
		endcase
		return r;
	endfunction

	// move to the phase that follows an expired one
	function automatic seq_t advance(input seq_t s);
		seq_t r;
		r = s;
		unique case (s.phase)
			PH_RST_LOW:  r = go(s, PH_RST_WAIT);
			PH_RST_WAIT: r = go(s, PH_RST_TAIL);
			PH_W_LOW:    r = go(s, PH_W_TAIL);
			PH_R_LOW:    r = go(s, PH_R_SAMPLE);
			PH_R_SAMPLE: r = go(s, PH_R_TAIL);
			PH_W_TAIL, PH_R_TAIL: begin
				if (s.bit_count == BIT_CNT_W'(BITS_PER_BYTE - 1)) begin
					r.bit_count = '0;
					r = go(r, PH_IDLE);
				end else begin
					r.bit_count = s.bit_count + BIT_CNT_W'(1);
					if (s.phase == PH_W_TAIL) begin
						r.send_shift = {1'b0, s.send_shift[7:1]};
						r = go(r, PH_W_LOW);
					end else begin
						r = go(r, PH_R_LOW);
					end
				end
			end
			default: r = go(s, PH_IDLE);
		endcase
		return r;
	endfunction

	assign cfg.ready    = 1'b1;
	assign item.ready   = !res_valid_q || result.ready;
	assign item_xfer    = item.valid && item.ready;
	assign result.valid = res_valid_q;
	assign result.payload = res_q;

	always_comb begin
		res_next = '0;
		s_start  = '{phase: phase_q, timer: timer_q, bit_count: bit_count_q,
		             send_shift: send_shift_q};
		recv_next = receive_shift_q;
		pres_next = presence_q;

		// command start; the start tick is already the first tick of the command
		if (phase_q == PH_IDLE) begin
			unique case (item.payload.func)
				FUNC_RESET: s_start = go(s_start, PH_RST_LOW);
				FUNC_WRITE: begin
					s_start.send_shift = item.payload.data_byte;
					s_start.bit_count  = '0;
					s_start = go(s_start, PH_W_LOW);
				end
				FUNC_READ: begin
					s_start.bit_count = '0;
					s_start = go(s_start, PH_R_LOW);
				end
				default: s_start = s_start;
			endcase
		end else if (item.payload.func != FUNC_TICK) begin
			res_next.rejected = 1'b1;
		end

		s_adv1 = s_start;
		s_adv2 = s_start;
		s_next = s_start;
		if (s_start.phase != PH_IDLE) begin
			res_next.busy_res  = 1'b1;
			res_next.drive_low = (s_start.phase == PH_RST_LOW) || (s_start.phase == PH_W_LOW) ||
			                     (s_start.phase == PH_R_LOW);
			if (s_start.phase == PH_RST_WAIT && s_start.timer == TW'(1)) begin
				pres_next = item.payload.line_level;
			end
			if (s_start.phase == PH_R_SAMPLE) begin
				recv_next = {item.payload.line_level, receive_shift_q[7:1]};
			end
			if (s_start.timer != '0) begin
				s_adv1.timer = s_start.timer - TW'(1);
			end
			// a zero tail can chain at most two phase changes in one tick
			s_adv2 = s_adv1;
			if (s_adv1.timer == '0) begin
				s_adv2 = advance(s_adv1);
			end
			s_next = s_adv2;
			if (s_adv2.phase != PH_IDLE && s_adv2.timer == '0) begin
				s_next = advance(s_adv2);
			end
			res_next.done_res = (s_next.phase == PH_IDLE);
		end
		res_next.read_data   = recv_next;
		res_next.no_presence = pres_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[IDX_RESET_LOW]      <= RST_RESET_LOW;
			cfg_q[IDX_PRESENCE_WAIT]  <= RST_PRESENCE_WAIT;
			cfg_q[IDX_RESET_TAIL]     <= RST_RESET_TAIL;
			cfg_q[IDX_WRITE_ONE_LOW]  <= RST_WRITE_ONE_LOW;
			cfg_q[IDX_WRITE_ZERO_LOW] <= RST_WRITE_ZERO_LOW;
			cfg_q[IDX_SLOT_TAIL]      <= RST_SLOT_TAIL;
			cfg_q[IDX_READ_LOW]       <= RST_READ_LOW;
			cfg_q[IDX_RECOVERY]       <= RST_RECOVERY;
		end else if (cfg.valid && cfg.payload.index < CFG_IDX_W'(REG_COUNT)) begin
			cfg_q[cfg.payload.index[REG_IDX_W-1:0]] <= cfg.payload.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			timer_q         <= '0;
			bit_count_q     <= '0;
			send_shift_q    <= '0;
			receive_shift_q <= '0;
			presence_q      <= 1'b1;
			res_valid_q     <= 1'b0;
		end else begin
			if (item_xfer) begin
				phase_q         <= s_next.phase;
				timer_q         <= s_next.timer;
				bit_count_q     <= s_next.bit_count;
				send_shift_q    <= s_next.send_shift;
				receive_shift_q <= recv_next;
				presence_q      <= pres_next;
				res_valid_q     <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			res_q <= res_next;
		end
	end

`ifndef NO_ASSERTIONS
	// a running phase always has time left on the timer
	a_timer_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (timer_q != '0))
		else $error("running phase with expired timer");

	// a command while busy is flagged in the result of that transfer
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(item_xfer && phase_q != PH_IDLE && item.payload.func != FUNC_TICK)
		|=> (res_q.rejected && res_q.busy_res))
		else $error("busy command not flagged");

	// bus is only pulled low while a command runs
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.drive_low) |-> res_q.busy_res)
		else $error("line driven while not busy");

	// sequencer returns to idle with the bit counter cleared
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (bit_count_q == '0))
		else $error("bit counter left nonzero in idle");
`endif

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for onewire_bus_master_byte_top, the byte-level 1-Wire master.
// Depends on obm_pkg, the channel interfaces in obm_ifs.sv and onewire_bus_master_byte_top.
// A scoreboard class predicts every per-tick result, and plain tasks drive the three channels.
module tb;
	import obm_pkg::*;

	// Sequencer phases of the bus master, as the predictor tracks them.
	typedef enum logic [PHASE_W-1:0] {
		BUS_IDLE, RST_LOW, RST_WAIT, RST_TAIL, WR_LOW, WR_TAIL, RD_LOW, RD_SAMPLE, RD_TAIL
	} bus_phase_e;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PHASES  = 8;
	localparam int TICKS_PER_PHASE = 116;
	localparam int LINE_LOW    = 0;
	localparam int LINE_HIGH   = 1;
	localparam int LINE_RANDOM = 2;

	// Predicts the result of every tick and checks the results that arrive against it.
	class obm_tick_scoreboard;
		logic [REG_W-1:0]          timing [REG_COUNT];
		bus_phase_e                phase;
		logic [TIMER_BITS_DEF-1:0] timer;
		logic [BIT_CNT_W-1:0]      bit_idx;
		logic [7:0]                tx_byte;
		logic [7:0]                rx_byte;
		logic                      presence;
		result_t                   tick_results_due [$];
		int mismatches, n_checked, n_reset, n_write, n_read, n_refused, n_present;

		function void reset_state();
			timing[IDX_RESET_LOW]      = RST_RESET_LOW;
			timing[IDX_PRESENCE_WAIT]  = RST_PRESENCE_WAIT;
			timing[IDX_RESET_TAIL]     = RST_RESET_TAIL;
			timing[IDX_WRITE_ONE_LOW]  = RST_WRITE_ONE_LOW;
			timing[IDX_WRITE_ZERO_LOW] = RST_WRITE_ZERO_LOW;
			timing[IDX_SLOT_TAIL]      = RST_SLOT_TAIL;
			timing[IDX_READ_LOW]       = RST_READ_LOW;
			timing[IDX_RECOVERY]       = RST_RECOVERY;
			phase = BUS_IDLE;
			timer = '0;
			bit_idx = '0;
			tx_byte = '0;
			rx_byte = '0;
			presence = 1'b1;
		endfunction

		function void write_timing(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
			if (idx < REG_COUNT) begin
				timing[idx[REG_IDX_W-1:0]] = value;
			end
		endfunction

		function bit bus_idle();
			return phase == BUS_IDLE;
		endfunction

		function int pending();
			return tick_results_due.size();
		endfunction

		// Phase length: low and wait times of zero act as one, all saturate to the timer.
		function logic [TIMER_BITS_DEF-1:0] span(logic [REG_W-1:0] value, bit at_least_one);
			int len;
			len = int'(value);
			if (at_least_one && len == 0) begin
				len = 1;
			end
			if (len > (1 << TIMER_BITS_DEF) - 1) begin
				len = (1 << TIMER_BITS_DEF) - 1;
			end
			return len[TIMER_BITS_DEF-1:0];
		endfunction

		function void enter(bus_phase_e next);
			case (next)
				RST_LOW:   timer = span(timing[IDX_RESET_LOW], 1'b1);
				RST_WAIT:  timer = span(timing[IDX_PRESENCE_WAIT], 1'b1);
				RST_TAIL:  timer = span(timing[IDX_RESET_TAIL], 1'b0);
				WR_LOW:    timer = span(tx_byte[0] ? timing[IDX_WRITE_ONE_LOW]
					: timing[IDX_WRITE_ZERO_LOW], 1'b1);
				WR_TAIL:   timer = span(tx_byte[0] ? timing[IDX_SLOT_TAIL]
					: timing[IDX_RECOVERY], 1'b0);
				RD_LOW:    timer = span(timing[IDX_READ_LOW], 1'b1);
				RD_SAMPLE: timer = TIMER_BITS_DEF'(1);
				RD_TAIL:   timer = span(timing[IDX_SLOT_TAIL], 1'b0);
				default:   timer = '0;
			endcase
			phase = next;
		endfunction

		function void advance();
			case (phase)
				RST_LOW:   enter(RST_WAIT);
				RST_WAIT:  enter(RST_TAIL);
				WR_LOW:    enter(WR_TAIL);
				RD_LOW:    enter(RD_SAMPLE);
				RD_SAMPLE: enter(RD_TAIL);
				WR_TAIL, RD_TAIL: begin
					if (bit_idx == BITS_PER_BYTE - 1) begin
						bit_idx = '0;
						enter(BUS_IDLE);
					end else begin
						bit_idx = bit_idx + 1'b1;
						if (phase == WR_TAIL) begin
							tx_byte = tx_byte >> 1;
							enter(WR_LOW);
						end else begin
							enter(RD_LOW);
						end
					end
				end
				default: enter(BUS_IDLE);
			endcase
		endfunction

		// One accepted tick: start or refuse a command, run the sequencer, queue the result.
		function void note_tick(item_t it);
			result_t want;
			want = '0;
			if (phase == BUS_IDLE) begin
				case (it.func)
					FUNC_RESET: begin
						n_reset++;
						enter(RST_LOW);
					end
					FUNC_WRITE: begin
						n_write++;
						tx_byte = it.data_byte;
						bit_idx = '0;
						enter(WR_LOW);
					end
					FUNC_READ: begin
						n_read++;
						bit_idx = '0;
						enter(RD_LOW);
					end
					default: ;
				endcase
			end else if (it.func != FUNC_TICK) begin
				want.rejected = 1'b1;
				n_refused++;
			end
			if (phase != BUS_IDLE) begin
				want.busy_res = 1'b1;
				want.drive_low = (phase == RST_LOW) || (phase == WR_LOW) || (phase == RD_LOW);
				if (phase == RST_WAIT && timer == 1) begin
					presence = it.line_level;
					if (!it.line_level) n_present++;
				end
				if (phase == RD_SAMPLE) begin
					rx_byte = {it.line_level, rx_byte[7:1]};
				end
				if (timer != 0) begin
					timer = timer - 1'b1;
				end
				while (phase != BUS_IDLE && timer == 0) begin
					advance();
				end
				if (phase == BUS_IDLE) begin
					want.done_res = 1'b1;
				end
			end
			want.read_data = rx_byte;
			want.no_presence = presence;
			tick_results_due.push_back(want);
		endfunction

		function void log_mismatch(string why, result_t want, result_t got);
			mismatches++;
			if (mismatches <= 10) begin
				$display("[%0t] %s: expected drive=%b busy=%b done=%b data=%h nopres=%b rej=%b",
					$time, why, want.drive_low, want.busy_res, want.done_res, want.read_data,
					want.no_presence, want.rejected);
				$display("    actual   drive=%b busy=%b done=%b data=%h nopres=%b rej=%b",
					got.drive_low, got.busy_res, got.done_res, got.read_data,
					got.no_presence, got.rejected);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			bit wrong;
			n_checked++;
			if (tick_results_due.size() == 0) begin
				log_mismatch("result with nothing expected", '0, got);
				return;
			end
			want = tick_results_due.pop_front();
			wrong = (got.drive_low !== want.drive_low) || (got.busy_res !== want.busy_res)
				|| (got.done_res !== want.done_res) || (got.read_data !== want.read_data)
				|| (got.no_presence !== want.no_presence) || (got.rejected !== want.rejected);
			if (wrong) begin
				log_mismatch("result field mismatch", want, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	obm_item_if   item_ch ();
	obm_result_if res_ch ();
	obm_cfg_if    cfg_ch ();

	onewire_bus_master_byte_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	obm_tick_scoreboard sb = new();

	// Traffic shaping knobs, changed between phases of the run.
	int sender_idle_pct = 0;
	int stall_pct = 0;
	int ticks_sent = 0;
	int settings_used = 0;
	int idle_cycles = 0;
	logic [REG_W-1:0] plan [REG_COUNT];

	// 8-unit clock period
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Receiver back-pressure, redrawn every falling edge.
	always @(negedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Result monitor: every accepted result goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			sb.check_result(res_ch.payload);
		end
	end

	// Watchdog: ends the run when no channel moves a transfer for too long.
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results still due",
				WATCHDOG_LIMIT, sb.pending());
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic logic pick_line(int line_mode);
		case (line_mode)
			LINE_LOW:  return 1'b0;
			LINE_HIGH: return 1'b1;
			default:   return 1'($urandom_range(1));
		endcase
	endfunction

	// One tick transfer. Entered and left at a falling edge; random sender gaps come first.
	task automatic send_item(input item_t it);
		while ($urandom_range(99) < sender_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.payload <= it;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_tick(it);
		ticks_sent++;
		@(negedge clk);
	endtask

	// Starts one command, then ticks until the predicted sequencer is idle again.
	// poke is sent on the tick after the start, while the command still runs.
	task automatic run_command(input logic [1:0] op, input logic [7:0] value,
		input int line_mode, input logic [1:0] poke);
		item_t it;
		bit first;
		first = 1'b1;
		it.func = op;
		it.data_byte = value;
		it.line_level = pick_line(line_mode);
		send_item(it);
		while (!sb.bus_idle()) begin
			it.func = first ? poke : FUNC_TICK;
			it.data_byte = 8'($urandom);
			it.line_level = pick_line(line_mode);
			send_item(it);
			first = 1'b0;
		end
	endtask

	// Ticks the running command out, then waits for every result to arrive plus a little.
	task automatic settle();
		item_t it;
		while (!sb.bus_idle()) begin
			it.func = FUNC_TICK;
			it.data_byte = 8'($urandom);
			it.line_level = 1'($urandom_range(1));
			send_item(it);
		end
		item_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
		cfg_t word;
		word.index = idx;
		word.data = value;
		cfg_ch.valid <= 1'b1;
		cfg_ch.payload <= word;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_timing(idx, value);
		@(negedge clk);
	endtask

	// Loads the plan into all eight registers once the bus is quiet, plus one stray write
	// to an unused index that must leave everything alone.
	task automatic program_timings();
		settle();
		for (int i = 0; i < REG_COUNT; i++) begin
			write_reg(CFG_IDX_W'(i), plan[i]);
		end
		write_reg(CFG_IDX_W'(REG_COUNT + $urandom_range(REG_COUNT - 1)), REG_W'($urandom));
		cfg_ch.valid <= 1'b0;
		settings_used++;
	endtask

	// Mostly short timings so a byte takes tens of ticks; a few zeros and longer ones mixed in.
	task automatic plan_random_timings();
		int roll;
		for (int i = 0; i < REG_COUNT; i++) begin
			roll = $urandom_range(99);
			if (roll < 12) begin
				plan[i] = '0;
			end else if (roll < 90) begin
				plan[i] = REG_W'($urandom_range(1, 4));
			end else begin
				plan[i] = REG_W'($urandom_range(5, 30));
			end
		end
	endtask

	// Random traffic: commands are mostly issued on an idle bus so they run to completion;
	// a few land on a busy bus and must be refused.
	task automatic random_ticks(input int count);
		item_t it;
		for (int i = 0; i < count; i++) begin
			if (sb.bus_idle()) begin
				it.func = ($urandom_range(99) < 40) ? 2'($urandom_range(1, 3)) : FUNC_TICK;
			end else begin
				it.func = ($urandom_range(99) < 6) ? 2'($urandom_range(1, 3)) : FUNC_TICK;
			end
			it.data_byte = 8'($urandom);
			it.line_level = 1'($urandom_range(1));
			send_item(it);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.payload = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.payload = '0;
		sb.reset_state();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Default timings straight out of reset: one write hit by a busy read.
		run_command(FUNC_WRITE, 8'hA5, LINE_RANDOM, FUNC_READ);

		// All timings zero: low and wait phases shrink to one tick, tails vanish.
		for (int i = 0; i < REG_COUNT; i++) plan[i] = '0;
		program_timings();
		run_command(FUNC_RESET, 8'h00, LINE_LOW, FUNC_RESET);
		run_command(FUNC_RESET, 8'hFF, LINE_HIGH, FUNC_TICK);
		run_command(FUNC_WRITE, 8'h00, LINE_RANDOM, FUNC_WRITE);
		run_command(FUNC_WRITE, 8'hFF, LINE_RANDOM, FUNC_TICK);
		run_command(FUNC_READ, 8'h00, LINE_LOW, FUNC_TICK);
		run_command(FUNC_READ, 8'hFF, LINE_HIGH, FUNC_READ);

		// Short nonzero timings, so each phase boundary lands on its own tick.
		plan[IDX_RESET_LOW] = 3;
		plan[IDX_PRESENCE_WAIT] = 2;
		plan[IDX_RESET_TAIL] = 1;
		plan[IDX_WRITE_ONE_LOW] = 1;
		plan[IDX_WRITE_ZERO_LOW] = 4;
		plan[IDX_SLOT_TAIL] = 2;
		plan[IDX_READ_LOW] = 1;
		plan[IDX_RECOVERY] = 3;
		program_timings();
		run_command(FUNC_RESET, 8'h00, LINE_LOW, FUNC_WRITE);
		run_command(FUNC_WRITE, 8'h5A, LINE_RANDOM, FUNC_RESET);
		run_command(FUNC_READ, 8'h00, LINE_RANDOM, FUNC_TICK);

		// Random phases, cycling through the traffic patterns: free flow, sparse sender,
		// heavy receiver stalls, then light gaps on both sides.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			sender_idle_pct = 0;
			stall_pct = 0;
			plan_random_timings();
			program_timings();
			case (p % 4)
				1: sender_idle_pct = 61;
				2: stall_pct = 61;
				3: begin
					sender_idle_pct = 12;
					stall_pct = 12;
				end
				default: ;
			endcase
			random_ticks(TICKS_PER_PHASE);
		end

		settle();
		$display("Ran %0d ticks over %0d timing settings: %0d resets (%0d answered), %0d writes,",
			ticks_sent, settings_used, sb.n_reset, sb.n_present, sb.n_write);
		$display("%0d reads and %0d refused commands; %0d results compared, %0d wrong.",
			sb.n_read, sb.n_refused, sb.n_checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- files.f -----
src/obm_pkg.sv
src/obm_ifs.sv
src/onewire_bus_master_byte_top.sv
verif/tb.sv
